FILE: design/psa_pkg.sv
// ----------------------------------------------------------------------------
// psa_pkg
// Source numbering and arbiter state codes for the packet source arbiter.
// ----------------------------------------------------------------------------
package psa_pkg;

  localparam int unsigned NUM_PORTS = 8;
  localparam int unsigned PORT_W    = 3;
  localparam int unsigned MASK_W    = 3;

  localparam logic [PORT_W-1:0] P_PARSER1 = 3'd0;
  localparam logic [PORT_W-1:0] P_PARSER2 = 3'd1;
  localparam logic [PORT_W-1:0] P_WQ1_NET = 3'd2;
  localparam logic [PORT_W-1:0] P_WQ1_SOC = 3'd3;
  localparam logic [PORT_W-1:0] P_WQ1_MEM = 3'd4;
  localparam logic [PORT_W-1:0] P_WQ2_NET = 3'd5;
  localparam logic [PORT_W-1:0] P_WQ2_MEM = 3'd6;
  localparam logic [PORT_W-1:0] P_DISP    = 3'd7;

  localparam int unsigned M_WQ1_MEM = 0;
  localparam int unsigned M_WQ1_SOC = 1;
  localparam int unsigned M_WQ1_NET = 2;

  typedef logic [NUM_PORTS-1:0] port_vec_t;

  typedef enum logic [2:0] {
    ST_READY   = 3'd0,
    ST_PARSER2 = 3'd1,
    ST_WQ1_MEM = 3'd2,
    ST_WQ1_SOC = 3'd3,
    ST_WQ1_NET = 3'd4,
    ST_WQ2_NET = 3'd5,
    ST_DISP    = 3'd6
  } arb_state_t;

endpackage

FILE: design/packet_source_arbiter_fsm.sv
// ----------------------------------------------------------------------------
// packet_source_arbiter_fsm
// Chooses which of eight source queues to pop per word and steers records.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one word per cycle unless
//   stalled: the not-empty, last and endpoint flags of all eight sources.
//   Result channel (out_valid / out_stall) returns one word per input word:
//   the pop decision, forwarded last flag, record steering and error flag.
//   An accepted input word is held in the input register, which feeds the
//   arbiter decision logic into the result register.
//   One word moves per cycle unless the receiver stalls; the arbiter state
//   updates in the same cycle the decision moves into the result register.
//   When the receiver stalls, the result register holds, the input register
//   fills, and in_stall rises once both are occupied.
//   Reset returns the arbiter to the ready state with the pending mask clear
//   and both registers empty.
// ----------------------------------------------------------------------------
module packet_source_arbiter_fsm (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  psa_pkg::port_vec_t      in_port_ready,
  input  psa_pkg::port_vec_t      in_head_last,
  input  psa_pkg::port_vec_t      in_head_is_mem,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_pop_valid,
  output logic [psa_pkg::PORT_W-1:0] out_pop_port,
  output logic                    out_last,
  output logic                    out_record_soc,
  output logic                    out_record_mem,
  output logic                    out_protocol_error
);
  import psa_pkg::*;

  logic                in_valid_r;
  port_vec_t           rdy_r, lst_r, mem_r;
  logic                out_valid_r;
  logic                pop_valid_r, last_r, rsoc_r, rmem_r, err_r;
  logic [PORT_W-1:0]   port_r;
  arb_state_t          state_r, state_nxt;
  logic [MASK_W-1:0]   mask_r, mask_nxt, mask_mem;

  logic                advance, in_take;
  logic                valid_c, rsoc_c, rmem_c, err_c, last_c;
  logic [PORT_W-1:0]   port_c;

  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  // pending mask as it stands after a wq1 memory header pop
  always_comb begin
    mask_mem = mask_r;
    if (!lst_r[P_WQ1_MEM]) mask_mem[M_WQ1_MEM] = 1'b1;
    if (rdy_r[P_WQ1_SOC])  mask_mem[M_WQ1_SOC] = 1'b1;
    if (rdy_r[P_WQ1_NET])  mask_mem[M_WQ1_NET] = 1'b1;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    mask_nxt  = mask_r;
    case (state_r)
      ST_PARSER2: begin
        if (rdy_r[P_PARSER2]) state_nxt = ST_READY;
      end
      ST_WQ1_MEM: begin
        if (rdy_r[P_WQ1_MEM] && lst_r[P_WQ1_MEM]) begin
          mask_nxt[M_WQ1_MEM] = 1'b0;
          if (mask_r[M_WQ1_SOC])      state_nxt = ST_WQ1_SOC;
          else if (mask_r[M_WQ1_NET]) state_nxt = ST_WQ1_NET;
          else                        state_nxt = ST_READY;
        end
      end
      ST_WQ1_SOC: begin
        if (rdy_r[P_WQ1_SOC]) begin
          mask_nxt[M_WQ1_SOC] = 1'b0;
          state_nxt = mask_r[M_WQ1_NET] ? ST_WQ1_NET : ST_READY;
        end
      end
      ST_WQ1_NET: begin
        if (rdy_r[P_WQ1_NET]) begin
          mask_nxt[M_WQ1_NET] = 1'b0;
          state_nxt = ST_READY;
        end
      end
      ST_WQ2_NET: begin
        if (rdy_r[P_WQ2_NET] && lst_r[P_WQ2_NET]) state_nxt = ST_READY;
      end
      ST_DISP: begin
        if (rdy_r[P_DISP] && lst_r[P_DISP]) state_nxt = ST_READY;
      end
      default: begin
        state_nxt = ST_READY;
        if (rdy_r[P_DISP]) begin
          if (!lst_r[P_DISP]) state_nxt = ST_DISP;
        end else if (rdy_r[P_WQ2_MEM]) begin
          if (rdy_r[P_WQ2_NET]) state_nxt = ST_WQ2_NET;
        end else if (rdy_r[P_WQ1_MEM]) begin
          mask_nxt = mask_mem;
          if (mask_mem[M_WQ1_MEM])      state_nxt = ST_WQ1_MEM;
          else if (mask_mem[M_WQ1_SOC]) state_nxt = ST_WQ1_SOC;
          else if (mask_mem[M_WQ1_NET]) state_nxt = ST_WQ1_NET;
        end else if (rdy_r[P_PARSER1]) begin
          if (rdy_r[P_PARSER2]) state_nxt = ST_PARSER2;
        end
      end
    endcase
  end

  // outputs
  always_comb begin
    valid_c = 1'b0;
    port_c  = '0;
    rsoc_c  = 1'b0;
    rmem_c  = 1'b0;
    err_c   = 1'b0;
    case (state_r)
      ST_PARSER2: begin
        if (rdy_r[P_PARSER2]) begin
          valid_c = 1'b1;
          port_c  = P_PARSER2;
          err_c   = !lst_r[P_PARSER2];
          rmem_c  = mem_r[P_PARSER2];
          rsoc_c  = !mem_r[P_PARSER2];
        end
      end
      ST_WQ1_MEM: begin
        if (rdy_r[P_WQ1_MEM]) begin
          valid_c = 1'b1;
          port_c  = P_WQ1_MEM;
        end
      end
      ST_WQ1_SOC: begin
        if (rdy_r[P_WQ1_SOC]) begin
          valid_c = 1'b1;
          port_c  = P_WQ1_SOC;
          err_c   = !lst_r[P_WQ1_SOC] || mem_r[P_WQ1_SOC];
          rsoc_c  = !mem_r[P_WQ1_SOC];
        end
      end
      ST_WQ1_NET: begin
        if (rdy_r[P_WQ1_NET]) begin
          valid_c = 1'b1;
          port_c  = P_WQ1_NET;
          err_c   = !lst_r[P_WQ1_NET];
        end
      end
      ST_WQ2_NET: begin
        if (rdy_r[P_WQ2_NET]) begin
          valid_c = 1'b1;
          port_c  = P_WQ2_NET;
        end
      end
      ST_DISP: begin
        if (rdy_r[P_DISP]) begin
          valid_c = 1'b1;
          port_c  = P_DISP;
        end
      end
      default: begin
        err_c = (mask_r != '0);
        if (rdy_r[P_DISP]) begin
          valid_c = 1'b1;
          port_c  = P_DISP;
        end else if (rdy_r[P_WQ2_MEM]) begin
          valid_c = 1'b1;
          port_c  = P_WQ2_MEM;
          err_c   = err_c || !lst_r[P_WQ2_MEM] || !mem_r[P_WQ2_MEM];
          rmem_c  = mem_r[P_WQ2_MEM];
        end else if (rdy_r[P_WQ1_MEM]) begin
          valid_c = 1'b1;
          port_c  = P_WQ1_MEM;
          err_c   = err_c || !mem_r[P_WQ1_MEM];
          rmem_c  = mem_r[P_WQ1_MEM];
        end else if (rdy_r[P_PARSER1]) begin
          valid_c = 1'b1;
          port_c  = P_PARSER1;
          err_c   = err_c || !lst_r[P_PARSER1];
          rmem_c  = mem_r[P_PARSER1];
          rsoc_c  = !mem_r[P_PARSER1];
        end
      end
    endcase
    last_c = valid_c && lst_r[port_c];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= ST_READY;
      mask_r      <= '0;
    end else begin
      if (in_take)              in_valid_r <= 1'b1;
      else if (advance)         in_valid_r <= 1'b0;
      if (advance)              out_valid_r <= 1'b1;
      else if (!out_stall)      out_valid_r <= 1'b0;
      if (advance) begin
        state_r <= state_nxt;
        mask_r  <= mask_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      rdy_r <= in_port_ready;
      lst_r <= in_head_last;
      mem_r <= in_head_is_mem;
    end
    if (advance) begin
      pop_valid_r <= valid_c;
      port_r      <= port_c;
      last_r      <= last_c;
      rsoc_r      <= rsoc_c;
      rmem_r      <= rmem_c;
      err_r       <= err_c;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_pop_valid      = pop_valid_r;
  assign out_pop_port       = port_r;
  assign out_last           = last_r;
  assign out_record_soc     = rsoc_r;
  assign out_record_mem     = rmem_r;
  assign out_protocol_error = err_r;

`ifndef SYNTHESIS
  a_idle_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !pop_valid_r) |-> (port_r == '0 && !last_r && !rsoc_r && !rmem_r))
    else $error("idle result word carries nonzero fields");

  a_record_one_target: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(rsoc_r && rmem_r))
    else $error("record steered to both trackers");

  a_wq1_mem_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WQ1_MEM) |-> mask_r[M_WQ1_MEM])
    else $error("wq1 memory lock without pending beat");

  a_wq1_net_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WQ1_NET) |-> mask_r[M_WQ1_NET])
    else $error("wq1 network lock without pending flag");
`endif

endmodule

FILE: dv/packet_source_arbiter_fsm_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// packet_source_arbiter_fsm_tb
// Self-checking bench for the packet source arbiter. Directed words walk the
// idle priority order, every follow-on lock and each error condition; then
// random words, mostly well-formed source sequences mixed with noise, run
// under bursty sending and several receiver stall patterns. Each result word
// is compared against an in-bench prediction of the arbiter.
// ----------------------------------------------------------------------------
module packet_source_arbiter_fsm_tb;
  import psa_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 7;
  localparam int STALL_LIMIT  = 500;
  localparam int RANDOM_WORDS = 700;
  localparam int STRETCH      = 100;
  localparam int DRAIN_CYCLES = 8;
  localparam int REPORT_MAX   = 10;

  typedef enum int {
    RX_FLOW,
    RX_RANDOM,
    RX_RUNS
  } rx_mode_t;

  typedef struct packed {
    logic              pop_valid;
    logic [PORT_W-1:0] pop_port;
    logic              last;
    logic              record_soc;
    logic              record_mem;
    logic              protocol_error;
  } pop_decision_t;

  logic              clk            = 1'b0;
  logic              rst_n          = 1'b0;
  logic              in_valid       = 1'b0;
  logic              in_stall;
  port_vec_t         in_port_ready  = '0;
  port_vec_t         in_head_last   = '0;
  port_vec_t         in_head_is_mem = '0;
  logic              out_valid;
  logic              out_stall      = 1'b0;
  logic              out_pop_valid;
  logic [PORT_W-1:0] out_pop_port;
  logic              out_last;
  logic              out_record_soc;
  logic              out_record_mem;
  logic              out_protocol_error;

  arb_state_t        model_state = ST_READY;
  logic [MASK_W-1:0] model_mask  = '0;
  pop_decision_t     pending_decisions[$];

  int       mismatch_count = 0;
  int       idle_cycles    = 0;
  int       burst_left     = 0;
  int       stall_run_left = 0;
  logic     stall_run_val  = 1'b0;
  bit       stim_active    = 1'b1;
  bit       sender_bursty  = 1'b0;
  rx_mode_t rx_mode        = RX_FLOW;

  packet_source_arbiter_fsm dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_port_ready      (in_port_ready),
    .in_head_last       (in_head_last),
    .in_head_is_mem     (in_head_is_mem),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_pop_valid      (out_pop_valid),
    .out_pop_port       (out_pop_port),
    .out_last           (out_last),
    .out_record_soc     (out_record_soc),
    .out_record_mem     (out_record_mem),
    .out_protocol_error (out_protocol_error)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic port_vec_t port_bit(input logic [PORT_W-1:0] p);
    return port_vec_t'(1) << p;
  endfunction

  // Advance the arbiter state by one word and return its decision.
  function automatic pop_decision_t arbitrate_word(input port_vec_t rdy, input port_vec_t lst,
                                                   input port_vec_t mem);
    pop_decision_t     d;
    arb_state_t        st;
    logic [MASK_W-1:0] mask;
    d    = '0;
    st   = model_state;
    mask = model_mask;
    case (model_state)
      ST_PARSER2: begin
        if (rdy[P_PARSER2]) begin
          d.pop_valid = 1'b1;
          d.pop_port  = P_PARSER2;
          if (!lst[P_PARSER2]) d.protocol_error = 1'b1;
          st = ST_READY;
          if (mem[P_PARSER2]) d.record_mem = 1'b1;
          else d.record_soc = 1'b1;
        end
      end
      ST_WQ1_MEM: begin
        if (rdy[P_WQ1_MEM]) begin
          d.pop_valid = 1'b1;
          d.pop_port  = P_WQ1_MEM;
          if (lst[P_WQ1_MEM]) begin
            mask[M_WQ1_MEM] = 1'b0;
            if (mask[M_WQ1_SOC]) st = ST_WQ1_SOC;
            else if (mask[M_WQ1_NET]) st = ST_WQ1_NET;
            else st = ST_READY;
          end
        end
      end
      ST_WQ1_SOC: begin
        if (rdy[P_WQ1_SOC]) begin
          d.pop_valid = 1'b1;
          d.pop_port  = P_WQ1_SOC;
          if (!lst[P_WQ1_SOC]) d.protocol_error = 1'b1;
          mask[M_WQ1_SOC] = 1'b0;
          st = mask[M_WQ1_NET] ? ST_WQ1_NET : ST_READY;
          if (mem[P_WQ1_SOC]) d.protocol_error = 1'b1;
          else d.record_soc = 1'b1;
        end
      end
      ST_WQ1_NET: begin
        if (rdy[P_WQ1_NET]) begin
          d.pop_valid = 1'b1;
          d.pop_port  = P_WQ1_NET;
          if (!lst[P_WQ1_NET]) d.protocol_error = 1'b1;
          mask[M_WQ1_NET] = 1'b0;
          st = ST_READY;
        end
      end
      ST_WQ2_NET: begin
        if (rdy[P_WQ2_NET]) begin
          d.pop_valid = 1'b1;
          d.pop_port  = P_WQ2_NET;
          if (lst[P_WQ2_NET]) st = ST_READY;
        end
      end
      ST_DISP: begin
        if (rdy[P_DISP]) begin
          d.pop_valid = 1'b1;
          d.pop_port  = P_DISP;
          if (lst[P_DISP]) st = ST_READY;
        end
      end
      default: begin
        if (mask != '0) d.protocol_error = 1'b1;
        if (rdy[P_DISP]) begin
          d.pop_valid = 1'b1;
          d.pop_port  = P_DISP;
          if (!lst[P_DISP]) st = ST_DISP;
        end else if (rdy[P_WQ2_MEM]) begin
          d.pop_valid = 1'b1;
          d.pop_port  = P_WQ2_MEM;
          if (!lst[P_WQ2_MEM]) d.protocol_error = 1'b1;
          if (rdy[P_WQ2_NET]) st = ST_WQ2_NET;
          if (mem[P_WQ2_MEM]) d.record_mem = 1'b1;
          else d.protocol_error = 1'b1;
        end else if (rdy[P_WQ1_MEM]) begin
          d.pop_valid = 1'b1;
          d.pop_port  = P_WQ1_MEM;
          if (!lst[P_WQ1_MEM]) mask[M_WQ1_MEM] = 1'b1;
          if (rdy[P_WQ1_SOC]) mask[M_WQ1_SOC] = 1'b1;
          if (rdy[P_WQ1_NET]) mask[M_WQ1_NET] = 1'b1;
          if (mask[M_WQ1_MEM]) st = ST_WQ1_MEM;
          else if (mask[M_WQ1_SOC]) st = ST_WQ1_SOC;
          else if (mask[M_WQ1_NET]) st = ST_WQ1_NET;
          if (mem[P_WQ1_MEM]) d.record_mem = 1'b1;
          else d.protocol_error = 1'b1;
        end else if (rdy[P_PARSER1]) begin
          d.pop_valid = 1'b1;
          d.pop_port  = P_PARSER1;
          if (!lst[P_PARSER1]) d.protocol_error = 1'b1;
          if (rdy[P_PARSER2]) st = ST_PARSER2;
          if (mem[P_PARSER1]) d.record_mem = 1'b1;
          else d.record_soc = 1'b1;
        end
      end
    endcase
    d.last      = d.pop_valid ? lst[d.pop_port] : 1'b0;
    model_state = st;
    model_mask  = mask;
    return d;
  endfunction

  task automatic send_word(input port_vec_t rdy, input port_vec_t lst, input port_vec_t mem);
    int gap;
    @(negedge clk);
    in_valid       <= 1'b1;
    in_port_ready  <= rdy;
    in_head_last   <= lst;
    in_head_is_mem <= mem;
    do @(posedge clk); while (in_stall);
    pending_decisions.push_back(arbitrate_word(rdy, lst, mem));
    if (sender_bursty) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        gap        = $urandom_range(1, 10);
        burst_left = $urandom_range(0, 15);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic test_dispatch_burst();
    send_word('0, '0, '0);
    send_word('1, '1, '1);
    send_word('1, '0, '0);
    send_word('0, '1, '1);
    send_word(port_bit(P_DISP), port_bit(P_DISP), '0);
  endtask

  task automatic test_idle_priority();
    send_word(port_bit(P_WQ2_MEM) | port_bit(P_WQ1_MEM) | port_bit(P_PARSER1), '1, '1);
    send_word(port_bit(P_WQ1_MEM) | port_bit(P_PARSER1), '1, '1);
    send_word(port_bit(P_PARSER1), '1, '0);
  endtask

  task automatic test_parser_pair();
    send_word(port_bit(P_PARSER1) | port_bit(P_PARSER2), '1, '0);
    send_word('0, '0, '0);
    send_word(port_bit(P_PARSER2), '1, '1);
  endtask

  task automatic test_wq1_chain();
    send_word(port_bit(P_WQ1_MEM) | port_bit(P_WQ1_SOC) | port_bit(P_WQ1_NET), '0, '1);
    send_word(port_bit(P_WQ1_MEM), '0, '1);
    send_word(port_bit(P_WQ1_MEM), port_bit(P_WQ1_MEM), '0);
    send_word(port_bit(P_WQ1_SOC), '1, '0);
    send_word(port_bit(P_WQ1_NET), '1, '0);
  endtask

  task automatic test_wq2_pair();
    send_word(port_bit(P_WQ2_MEM) | port_bit(P_WQ2_NET), '1, '1);
    send_word(port_bit(P_WQ2_NET), '0, '0);
    send_word(port_bit(P_WQ2_NET), '1, '0);
  endtask

  task automatic test_protocol_errors();
    send_word(port_bit(P_WQ2_MEM), '0, '0);
    send_word(port_bit(P_WQ1_MEM) | port_bit(P_WQ1_SOC), '1, '0);
    send_word(port_bit(P_WQ1_SOC), '0, '1);
    send_word(port_bit(P_PARSER1) | port_bit(P_PARSER2), '0, '0);
    send_word(port_bit(P_PARSER2), '0, '0);
    send_word(port_bit(P_WQ1_MEM) | port_bit(P_WQ1_NET), '1, '1);
    send_word(port_bit(P_WQ1_NET), '0, '0);
  endtask

  // Mostly feed the source the arbiter waits on, with plausible flags.
  task automatic send_random_word();
    port_vec_t         rdy;
    port_vec_t         lst;
    port_vec_t         mem;
    logic [PORT_W-1:0] target_port;
    rdy = port_vec_t'($urandom);
    lst = port_vec_t'($urandom);
    mem = port_vec_t'($urandom);
    if ($urandom_range(0, 99) >= 15) begin
      case (model_state)
        ST_PARSER2: target_port = P_PARSER2;
        ST_WQ1_MEM: target_port = P_WQ1_MEM;
        ST_WQ1_SOC: target_port = P_WQ1_SOC;
        ST_WQ1_NET: target_port = P_WQ1_NET;
        ST_WQ2_NET: target_port = P_WQ2_NET;
        ST_DISP:    target_port = P_DISP;
        default: begin
          case ($urandom_range(0, 3))
            0:       target_port = P_DISP;
            1:       target_port = P_WQ2_MEM;
            2:       target_port = P_WQ1_MEM;
            default: target_port = P_PARSER1;
          endcase
          if (target_port != P_DISP) rdy[P_DISP] = 1'b0;
          if (target_port == P_WQ1_MEM || target_port == P_PARSER1) rdy[P_WQ2_MEM] = 1'b0;
          if (target_port == P_PARSER1) rdy[P_WQ1_MEM] = 1'b0;
        end
      endcase
      rdy[target_port] = ($urandom_range(0, 99) < 85);
      lst[P_PARSER1]   = ($urandom_range(0, 99) < 92);
      lst[P_PARSER2]   = ($urandom_range(0, 99) < 92);
      lst[P_WQ1_SOC]   = ($urandom_range(0, 99) < 92);
      lst[P_WQ1_NET]   = ($urandom_range(0, 99) < 92);
      lst[P_WQ2_MEM]   = ($urandom_range(0, 99) < 92);
      lst[P_WQ1_MEM]   = ($urandom_range(0, 99) < 35);
      lst[P_WQ2_NET]   = ($urandom_range(0, 99) < 35);
      lst[P_DISP]      = ($urandom_range(0, 99) < 35);
      mem[P_WQ1_MEM]   = ($urandom_range(0, 99) < 92);
      mem[P_WQ2_MEM]   = ($urandom_range(0, 99) < 92);
      mem[P_WQ1_SOC]   = ($urandom_range(0, 99) >= 92);
    end
    send_word(rdy, lst, mem);
  endtask

  task automatic test_random_traffic();
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % STRETCH == 0) begin
        sender_bursty = ((i / STRETCH) % 2) == 1;
        rx_mode       = rx_mode_t'((i / STRETCH) % 3);
      end
      send_random_word();
    end
  endtask

  always @(negedge clk) begin : drive_out_stall
    case (rx_mode)
      RX_FLOW:   out_stall <= 1'b0;
      RX_RANDOM: out_stall <= ($urandom_range(0, 99) < 35);
      default: begin
        if (stall_run_left == 0) begin
          stall_run_val  = !stall_run_val;
          stall_run_left = $urandom_range(1, 12);
        end else begin
          stall_run_left--;
        end
        out_stall <= stall_run_val;
      end
    endcase
  end

  always @(posedge clk) begin : check_results
    pop_decision_t got;
    pop_decision_t exp_word;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_pop_valid, out_pop_port, out_last, out_record_soc, out_record_mem,
             out_protocol_error};
      if (pending_decisions.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("unexpected result word at %0t: %h", $realtime, got);
      end else begin
        exp_word = pending_decisions.pop_front();
        if (got !== exp_word) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX) begin
            $write("mismatch at %0t: exp valid=%b port=%0d last=%b soc=%b mem=%b err=%b, ",
                   $realtime, exp_word.pop_valid, exp_word.pop_port, exp_word.last,
                   exp_word.record_soc, exp_word.record_mem, exp_word.protocol_error);
            $display("got valid=%b port=%0d last=%b soc=%b mem=%b err=%b",
                     got.pop_valid, got.pop_port, got.last, got.record_soc,
                     got.record_mem, got.protocol_error);
          end
        end
      end
    end
  end

  initial begin : watchdog
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else if (rst_n && (stim_active || pending_decisions.size() != 0)) idle_cycles++;
    end
    $display("FAIL packet_source_arbiter_fsm");
    $finish;
  end

  initial begin
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    test_dispatch_burst();
    test_idle_priority();
    test_parser_pair();
    test_wq1_chain();
    test_wq2_pair();
    test_protocol_errors();
    test_random_traffic();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_decisions.size() != 0) @(posedge clk);
    stim_active = 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_decisions.size() == 0)
      $display("PASS packet_source_arbiter_fsm");
    else
      $display("FAIL packet_source_arbiter_fsm");
    $finish;
  end

endmodule
